/* rtl/core/deq_pkg.sv */
package deq_pkg;

    // Queue geometry.
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int FILL_W = 11;
    localparam int OP_W   = 3;

    typedef logic signed [WORD_W-1:0] t_word;

    // Operation codes carried with each input item.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_NOP        = 3'd4
    } t_op;

    // What one storage cell does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_LOW,
        CELL_TAKE_HIGH,
        CELL_LOAD
    } t_cell_op;

    // What a whole chain does in a cycle.
    typedef enum logic [1:0] {
        CHAIN_HOLD,
        CHAIN_PUSH,
        CHAIN_POP,
        CHAIN_WRITE
    } t_chain_act;

    // Command from the control logic to one chain.
    typedef struct packed {
        t_chain_act         act;
        logic [IDX_W-1:0]   pos;
        t_word              data;
    } t_chain_ctl;

endpackage

/* rtl/core/double_ended_queue.sv */
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: value; tuser: op
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: popped, fill, front, back;
//                                              tuser: underflow, overflow, is_empty
//
// The two cell rows update in the cycle of the transfer
// and the result is held in the output register until it is taken.
// Words are kept twice, front first in one row and back first in the other, so the
// front and back words always sit in the first cell of a row.
// A new item is taken while a result waits only if that result leaves in the same cycle.
// Reset (synchronous, active low) empties the queue; the cells themselves are not cleared.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // [31:0] value
    input  logic [2:0]    s_axis_tuser,   // [2:0] op
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // [31:0] popped_value, [42:32] fill_count,
                                          // [74:43] front_value, [106:75] back_value
    output logic [2:0]    m_axis_tuser    // [0] underflow, [1] overflow, [2] is_empty
);

    logic             r_out_valid;
    logic             n_out_valid;
    t_word            r_popped;
    t_word            n_popped;
    logic             r_under;
    logic             n_under;
    logic             r_over;
    logic             n_over;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_word            w_front;
    t_word            w_back;
    t_word            w_value;
    t_chain_ctl       w_ctl_front;
    t_chain_ctl       w_ctl_back;

    assign w_value  = t_word'(s_axis_tdata);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    // An item enters when the output register is free or being emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Decode the operation into chain commands, count update and result flags.
    always_comb begin
        w_ctl_front.act  = CHAIN_HOLD;
        w_ctl_front.pos  = IDX_W'(r_count);
        w_ctl_front.data = w_value;
        w_ctl_back.act   = CHAIN_HOLD;
        w_ctl_back.pos   = IDX_W'(r_count);
        w_ctl_back.data  = w_value;
        n_count          = r_count;
        n_popped         = r_popped;
        n_under          = r_under;
        n_over           = r_over;
        n_out_valid      = r_out_valid && !m_axis_tready;

        if (w_accept) begin
            n_out_valid = 1'b1;
            n_popped    = '0;
            n_under     = 1'b0;
            n_over      = 1'b0;
            unique case (s_axis_tuser)
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_over = 1'b1;
                    end else begin
                        w_ctl_front.act = CHAIN_PUSH;
                        w_ctl_back.act  = CHAIN_WRITE;
                        n_count         = r_count + CNT_W'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_over = 1'b1;
                    end else begin
                        w_ctl_back.act  = CHAIN_PUSH;
                        w_ctl_front.act = CHAIN_WRITE;
                        n_count         = r_count + CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_under = 1'b1;
                    end else begin
                        n_popped        = w_front;
                        w_ctl_front.act = CHAIN_POP;
                        n_count         = r_count - CNT_W'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        n_under = 1'b1;
                    end else begin
                        n_popped       = w_back;
                        w_ctl_back.act = CHAIN_POP;
                        n_count        = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_popped <= n_popped;
        r_under  <= n_under;
        r_over   <= n_over;
    end

    // Row with the front word in its first cell.
    deq_chain u_front_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl_front),
        .o_first (w_front)
    );

    // Row with the back word in its first cell.
    deq_chain u_back_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl_back),
        .o_first (w_back)
    );

    // The live count and end words belong to the held result, since the state
    // only moves when that result is taken.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0,
                            w_empty ? t_word'('0) : w_back,
                            w_empty ? t_word'('0) : w_front,
                            FILL_W'(r_count),
                            r_popped};
    assign m_axis_tuser  = {w_empty, r_over, r_under};

    // An overflow is only reported with a full queue.
    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_over |-> w_full)
        else $error("overflow reported while the queue is not full");

    // An underflow is only reported with an empty queue.
    a_under_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_under |-> w_empty)
        else $error("underflow reported while the queue holds words");

    // With one word stored, both rows must agree on it.
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'(1) |-> w_front == w_back)
        else $error("front and back rows disagree on a single word");

    // A successful pop lowers the count by exactly one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_empty &&
        (s_axis_tuser == OP_POP_FRONT || s_axis_tuser == OP_POP_BACK)
        |=> r_count == CNT_W'($past(r_count) - CNT_W'(1)))
        else $error("count not lowered by a pop");

endmodule

/* rtl/core/deq_cell.sv */
module deq_cell
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  t_word    i_low,
    input  t_word    i_high,
    input  t_word    i_load,
    output t_word    o_data
);

    t_word r_data;
    t_word n_data;

    // Pick the next word: keep, take from a neighbor, or load a new word.
    always_comb begin
        unique case (i_op)
            CELL_HOLD:      n_data = r_data;
            CELL_TAKE_LOW:  n_data = i_low;
            CELL_TAKE_HIGH: n_data = i_high;
            CELL_LOAD:      n_data = i_load;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* rtl/core/deq_chain.sv */
module deq_chain
    import deq_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    output t_word      o_first
);

    t_word    w_data [DEPTH];
    t_word    w_low  [DEPTH];
    t_word    w_high [DEPTH];
    t_cell_op w_op   [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell

        // Neighbor words; the ends of the row see zeros.
        if (g == 0) begin : g_first
            assign w_low[g] = '0;
        end else begin : g_inner_low
            assign w_low[g] = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_high[g] = '0;
        end else begin : g_inner_high
            assign w_high[g] = w_data[g+1];
        end

        // Local decode of the chain command for this position.
        always_comb begin
            unique case (i_ctl.act)
                CHAIN_PUSH:  w_op[g] = (g == 0) ? CELL_LOAD : CELL_TAKE_LOW;
                CHAIN_POP:   w_op[g] = (g == DEPTH - 1) ? CELL_HOLD : CELL_TAKE_HIGH;
                CHAIN_WRITE: w_op[g] = (i_ctl.pos == IDX_W'(g)) ? CELL_LOAD : CELL_HOLD;
                default:     w_op[g] = CELL_HOLD;
            endcase
        end

        deq_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op[g]),
            .i_low  (w_low[g]),
            .i_high (w_high[g]),
            .i_load (i_ctl.data),
            .o_data (w_data[g])
        );
    end

    assign o_first = w_data[0];

endmodule

/* tb/sv/double_ended_queue_tb.sv */
module double_ended_queue_tb;
    import deq_pkg::*;

    // Op codes outside the defined set; the block treats them as no operation.
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // Length of the long receiver hold-off that stalls the block's input.
    localparam int SINK_HOLD_LEN  = 300;

    // One status word as the block reports it after a step.
    typedef struct packed {
        t_word             popped;
        logic              underflow;
        logic              overflow;
        logic [FILL_W-1:0] fill;
        logic              empty;
        t_word             front;
        t_word             back;
    } t_deque_status;

    // Keeps a shadow copy of the deque and the status words still owed by the block.
    class deque_scoreboard;
        t_word         ring_copy [DEPTH];
        int unsigned   head_pos;
        int unsigned   word_total;
        t_deque_status pending_status [$];
        int unsigned   mismatches;

        function new();
            head_pos   = 0;
            word_total = 0;
            mismatches = 0;
        endfunction

        function int unsigned slot(int unsigned offset);
            return (head_pos + offset) % DEPTH;
        endfunction

        // Apply one accepted request to the shadow deque and queue the status it yields.
        function void note_request(logic [OP_W-1:0] op, t_word value);
            t_deque_status st;
            st = '0;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (word_total >= DEPTH) begin
                        st.overflow = 1'b1;
                    end else if (op == OP_PUSH_FRONT) begin
                        head_pos = (head_pos + DEPTH - 1) % DEPTH;
                        ring_copy[head_pos] = value;
                        word_total++;
                    end else begin
                        ring_copy[slot(word_total)] = value;
                        word_total++;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (word_total == 0) begin
                        st.underflow = 1'b1;
                    end else if (op == OP_POP_FRONT) begin
                        st.popped = ring_copy[head_pos];
                        head_pos  = slot(1);
                        word_total--;
                    end else begin
                        st.popped = ring_copy[slot(word_total - 1)];
                        word_total--;
                    end
                end
                default: begin
                end
            endcase
            st.fill  = FILL_W'(word_total);
            st.empty = (word_total == 0);
            if (word_total != 0) begin
                st.front = ring_copy[head_pos];
                st.back  = ring_copy[slot(word_total - 1)];
            end
            pending_status.insert(pending_status.size(), st);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one delivered status word with the oldest one owed.
        function void check_response(logic [111:0] tdata, logic [2:0] tuser);
            t_deque_status want;
            if (pending_status.size() == 0) begin
                $error("status word delivered with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_status[0];
            pending_status.delete(0);
            compare_field("popped_value", want.popped,                tdata[31:0]);
            compare_field("fill_count",   WORD_W'(want.fill),         WORD_W'(tdata[42:32]));
            compare_field("front_value",  want.front,                 tdata[74:43]);
            compare_field("back_value",   want.back,                  tdata[106:75]);
            compare_field("underflow",    WORD_W'(want.underflow),    WORD_W'(tuser[0]));
            compare_field("overflow",     WORD_W'(want.overflow),     WORD_W'(tuser[1]));
            compare_field("is_empty",     WORD_W'(want.empty),        WORD_W'(tuser[2]));
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [31:0]   s_axis_tdata;   // [31:0] value
    logic [2:0]    s_axis_tuser;   // [2:0] op
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [111:0]  m_axis_tdata;   // [31:0] popped_value, [42:32] fill_count,
                                   // [74:43] front_value, [106:75] back_value
    logic [2:0]    m_axis_tuser;   // [0] underflow, [1] overflow, [2] is_empty

    deque_scoreboard deque_board = new();

    int src_idle_pct     = 0;
    int sink_stall_pct   = 0;
    int sink_hold_cycles = 0;

    double_ended_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Offer one request, idling first at the current rate, and record it on transfer.
    task automatic send_item(input logic [OP_W-1:0] op, input t_word value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        deque_board.note_request(op, value);
    endtask

    // Stop offering and wait until every status word owed has been delivered.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (deque_board.pending_status.size() != 0) @(posedge i_clk);
    endtask

    // Mostly random words, with the extremes mixed in now and then.
    function automatic t_word pick_word();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int push_weight);
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        if (roll < 14)
            return OP_NOP;
        if (roll < 14 + push_weight)
            return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    task automatic run_random(int n_items, int idle_pct, int stall_pct);
        int push_weight;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        push_weight    = $urandom_range(40, 60);
        repeat (n_items) send_item(pick_op(push_weight), pick_word());
        pause_until_drained();
    endtask

    // Receiver: check each status transfer, then choose the next ready level.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                deque_board.check_response(m_axis_tdata, m_axis_tuser);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: end the run when neither side has moved a transfer for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NOP;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pops, ignored codes, extreme words, head wrap below zero.
        send_item(OP_POP_FRONT,  32'h7FFF_FFFF);
        send_item(OP_POP_BACK,   32'h8000_0000);
        send_item(OP_NOP,        32'hFFFF_FFFF);
        send_item(OP_UNDEF_LO,   32'h5555_5555);
        send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(OP_PUSH_BACK,  32'h8000_0000);
        send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(OP_PUSH_BACK,  32'h0000_0000);
        send_item(OP_NOP,        32'hAAAA_AAAA);
        send_item(OP_UNDEF_HI,   32'h1234_5678);
        send_item(OP_POP_FRONT,  32'h0000_0000);
        send_item(OP_POP_BACK,   32'hFFFF_FFFF);
        send_item(OP_POP_FRONT,  32'h0000_0001);
        send_item(OP_POP_BACK,   32'h8000_0000);
        send_item(OP_POP_FRONT,  32'h0000_0000);
        send_item(OP_PUSH_BACK,  32'h0000_0001);
        send_item(OP_POP_FRONT,  32'h0000_0000);
        send_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
        send_item(OP_POP_BACK,   32'h0000_0000);
        send_item(OP_POP_BACK,   32'h0000_0000);
        pause_until_drained();

        // Long receiver hold-off while requests keep coming, so the input stalls.
        sink_hold_cycles = SINK_HOLD_LEN;
        run_random(50, 0, 0);

        run_random(95, 0, 0);
        run_random(95, 80, 0);
        run_random(95, 0, 80);
        run_random(95, 14, 14);

        repeat (8) @(posedge i_clk);
        if (deque_board.mismatches == 0 && deque_board.pending_status.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/deq_chain.sv
rtl/core/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
